// ----- design/acap_pkg.sv -----
`default_nettype none

package acap_pkg;

    localparam logic [3:0] PH_FORMAT = 4'd0;
    localparam logic [3:0] PH_SECLEN = 4'd1;
    localparam logic [3:0] PH_VENDOR = 4'd2;
    localparam logic [3:0] PH_TAG    = 4'd3;
    localparam logic [3:0] PH_RECLEN = 4'd4;
    localparam logic [3:0] PH_ATTR   = 4'd5;
    localparam logic [3:0] PH_VAL    = 4'd6;
    localparam logic [3:0] PH_STR    = 4'd7;
    localparam logic [3:0] PH_ULEB   = 4'd8;
    localparam logic [3:0] PH_ABSORB = 4'd9;

    localparam logic [1:0] VERDICT_OLD  = 2'd0;
    localparam logic [1:0] VERDICT_NEW  = 2'd1;
    localparam logic [1:0] VERDICT_FAIL = 2'd2;

    localparam logic [7:0] FORMAT_BYTE      = 8'h41;
    localparam logic [7:0] FILE_RECORD_TAG  = 8'd1;
    localparam logic [7:0] ARCH_ATTR_TAG    = 8'd6;
    localparam logic [7:0] ARCH_OLD_MAX     = 8'd5;
    localparam logic [31:0] RECORD_MIN_LEN  = 32'd5;
    localparam logic [31:0] LEN_FIELD_BYTES = 32'd4;

    typedef struct packed {
        logic       give;
        logic [1:0] verdict;
        logic [6:0] arch_value;
    } acap_result_t;

    function automatic logic is_string_tag(input logic [7:0] t);
        return (t == 8'd4) || (t == 8'd5) || (t == 8'd32) || (t == 8'd65) || (t == 8'd67);
    endfunction

    function automatic logic is_uleb_tag(input logic [7:0] t);
        return ((t >= 8'd7) && (t <= 8'd31)) || (t == 8'd34) || (t == 8'd36) ||
               (t == 8'd38) || (t == 8'd42) || (t == 8'd44) || (t == 8'd64) ||
               (t == 8'd66) || (t == 8'd68) || (t == 8'd70);
    endfunction

endpackage

`default_nettype wire

// ----- design/acap_in_if.sv -----
`default_nettype none

interface acap_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [31:0] section_size;

    modport source (output valid, output data_byte, output section_size, input ready);
    modport sink   (input valid, input data_byte, input section_size, output ready);
endinterface

`default_nettype wire

// ----- design/acap_out_if.sv -----
`default_nettype none

interface acap_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [6:0] cpu_arch_value;

    modport source (output valid, output verdict, output cpu_arch_value, input ready);
    modport sink   (input valid, input verdict, input cpu_arch_value, output ready);
endinterface

`default_nettype wire

// ----- design/arm_attributes_cpu_arch_parser.sv -----
// a verdict is registered and valid in the cycle after the byte that decides it is accepted
// throughput: one byte per cycle, sustained, while the result side keeps up
// a pending verdict stalls input only while it is not taken
// reset: asynchronous active low; parser returns to expecting a format byte, no result pending
`default_nettype none

module arm_attributes_cpu_arch_parser
    import acap_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    acap_in_if.sink     data,
    acap_out_if.source  result
);

    logic         accept;
    acap_result_t res;
    logic         out_valid_reg, out_valid_next;
    logic [1:0]   verdict_reg;
    logic [6:0]   arch_value_reg;

    assign data.ready = !out_valid_reg || result.ready;
    assign accept     = data.valid && data.ready;

    acap_parse u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data.data_byte),
        .section_size (data.section_size),
        .res          (res)
    );

    always_comb
    begin
        if (accept && res.give)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res.give)
        begin
            verdict_reg    <= res.verdict;
            arch_value_reg <= res.arch_value;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.verdict        = verdict_reg;
    assign result.cpu_arch_value = arch_value_reg;

endmodule

`default_nettype wire

// ----- design/acap_parse.sv -----
`default_nettype none

module acap_parse
    import acap_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    input  wire logic [31:0]  section_size,
    output acap_result_t      res
);

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] acc_reg, acc_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] rrem_reg, rrem_next;

    logic [31:0] rem_dec;
    logic [31:0] acc_new;
    logic        give;
    logic [1:0]  verdict;
    logic [6:0]  arch_value;
    logic        more;

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        rrem_next  = rrem_reg;
        give       = 1'b0;
        verdict    = VERDICT_FAIL;
        arch_value = 7'd0;
        rem_dec    = rem_reg - 32'd1;
        acc_new    = acc_reg | ({24'd0, data_byte} << {idx_reg, 3'b000});
        more       = (phase_reg == PH_STR) ? (data_byte != 8'd0) : data_byte[7];

        if (phase_reg == PH_FORMAT)
        begin
            if (section_size == 32'd0)
            begin
                rem_next = 32'd0;
                give     = 1'b1;
            end
            else
            begin
                rem_next = section_size - 32'd1;
                if (data_byte != FORMAT_BYTE || section_size <= LEN_FIELD_BYTES)
                begin
                    give = 1'b1;
                end
                else
                begin
                    acc_next   = 32'd0;
                    idx_next   = 2'd0;
                    phase_next = PH_SECLEN;
                end
            end
        end
        else if (phase_reg == PH_ABSORB)
        begin
            if (rem_reg != 32'd0)
            begin
                rem_next = rem_dec;
            end
            if (rem_reg <= 32'd1)
            begin
                phase_next = PH_FORMAT;
            end
        end
        else if (phase_reg > PH_ABSORB || rem_reg == 32'd0)
        begin
            rem_next = 32'd0;
            give     = 1'b1;
        end
        else
        begin
            rem_next = rem_dec;
            case (phase_reg)
                PH_SECLEN, PH_RECLEN:
                begin
                    acc_next = acc_new;
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        if (phase_reg == PH_SECLEN)
                        begin
                            if ({1'b0, acc_new} > ({1'b0, rem_reg} + 33'd3))
                            begin
                                give = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_VENDOR;
                            end
                        end
                        else
                        begin
                            if (acc_new <= RECORD_MIN_LEN)
                            begin
                                give = 1'b1;
                            end
                            else if ({1'b0, acc_new} > ({1'b0, rem_reg} + 33'd4))
                            begin
                                give = 1'b1;
                            end
                            else
                            begin
                                rrem_next  = acc_new - RECORD_MIN_LEN;
                                phase_next = PH_ATTR;
                            end
                        end
                    end
                end
                PH_VENDOR:
                begin
                    if (data_byte == 8'd0)
                    begin
                        phase_next = PH_TAG;
                    end
                end
                PH_TAG:
                begin
                    if (data_byte != FILE_RECORD_TAG || rem_dec < LEN_FIELD_BYTES)
                    begin
                        give = 1'b1;
                    end
                    else
                    begin
                        acc_next   = 32'd0;
                        idx_next   = 2'd0;
                        phase_next = PH_RECLEN;
                    end
                end
                PH_ATTR:
                begin
                    if (rrem_reg == 32'd0)
                    begin
                        give = 1'b1;
                    end
                    else
                    begin
                        rrem_next = rrem_reg - 32'd1;
                        if (data_byte == ARCH_ATTR_TAG)
                        begin
                            phase_next = PH_VAL;
                        end
                        else if (is_string_tag(data_byte) || is_uleb_tag(data_byte))
                        begin
                            if (rrem_reg == 32'd1)
                            begin
                                give = 1'b1;
                            end
                            else
                            begin
                                phase_next = is_string_tag(data_byte) ? PH_STR : PH_ULEB;
                            end
                        end
                        else
                        begin
                            give = 1'b1;
                        end
                    end
                end
                PH_VAL:
                begin
                    give = 1'b1;
                    if (!data_byte[7])
                    begin
                        verdict    = (data_byte <= ARCH_OLD_MAX) ? VERDICT_OLD : VERDICT_NEW;
                        arch_value = data_byte[6:0];
                    end
                end
                PH_STR, PH_ULEB:
                begin
                    if (rrem_reg == 32'd0)
                    begin
                        give = 1'b1;
                    end
                    else
                    begin
                        rrem_next = rrem_reg - 32'd1;
                        if (rrem_reg == 32'd1)
                        begin
                            give = 1'b1;
                        end
                        else if (!more)
                        begin
                            phase_next = PH_ATTR;
                        end
                    end
                end
                default:
                begin
                    give = 1'b1;
                end
            endcase
            // section ran out without a verdict
            if (!give && rem_dec == 32'd0)
            begin
                give = 1'b1;
            end
        end

        if (give)
        begin
            phase_next = (rem_next != 32'd0) ? PH_ABSORB : PH_FORMAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FORMAT;
            rem_reg   <= 32'd0;
            acc_reg   <= 32'd0;
            idx_reg   <= 2'd0;
            rrem_reg  <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            rrem_reg  <= rrem_next;
        end
    end

    assign res = '{give: give, verdict: verdict, arch_value: arch_value};

endmodule

`default_nettype wire

// ----- design/acap_checker.sv -----
`default_nettype none

module acap_checker
    import acap_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] verdict,
    input wire logic [6:0] cpu_arch_value
);

    // pending transaction holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(cpu_arch_value))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict == VERDICT_OLD || verdict == VERDICT_NEW || verdict == VERDICT_FAIL)
        else $error("illegal verdict code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_FAIL |-> cpu_arch_value == 7'd0)
        else $error("failure carries an architecture value");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != VERDICT_FAIL |->
            (verdict == VERDICT_OLD) == (cpu_arch_value <= 7'd5))
        else $error("verdict disagrees with architecture value");

endmodule

bind arm_attributes_cpu_arch_parser acap_checker u_acap_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (data.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .verdict        (result.verdict),
    .cpu_arch_value (result.cpu_arch_value)
);

`default_nettype wire
